// ----- rtl/akxor_pkg.sv -----
// Constants and payload types for the autokey XOR printable cipher unit.
`default_nettype none

package akxor_pkg;

    localparam logic [15:0] KEY_MUL    = 16'd52845;
    localparam logic [15:0] KEY_ADD    = 16'd22719;
    localparam logic [7:0]  CHAR_BASE  = 8'd33;
    localparam logic [7:0]  CHAR_RADIX = 8'd92;
    localparam logic [7:0]  BYTE_MASK  = 8'hff;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_SESSION_KEY  = 1'b0,
        REG_DECRYPT_MODE = 1'b1
    } cfg_reg_t;

    // Item held between the input register and the result register
    typedef struct packed {
        logic       start_of_message;
        logic [7:0] plain_byte;
        logic [7:0] cipher_value;  // pair folded back to one byte, before unmasking
    } stage_item_t;

endpackage

`default_nettype wire

// ----- rtl/autokey_xor_printable_cipher_unit.sv -----
// Top level of the autokey XOR printable cipher unit: stream in, stream out, config port.
`default_nettype none

// Takes one item per cycle while s_tready is high and gives one result item per accepted
// item, through the input register and then the result register. The first register folds a
// character pair into one byte; the second stage holds the 16-bit running key, whose
// update (one 16x16 constant multiply-add) closes the loop and sets the one-item-per-cycle
// rate. Config writes are always accepted (cfg_ready is tied high) and must only be issued
// while no item is in flight. In encrypt mode recovered_byte reads zero; in decrypt mode
// both printable characters read zero.
module autokey_xor_printable_cipher_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // tdata: plain_byte[7:0], cipher_high_char[15:8], cipher_low_char[23:16]
    input  wire logic [akxor_pkg::S_DATA_W-1:0] s_tdata,
    // tuser: start_of_message
    input  wire logic                          s_tuser,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // tdata: printable_high[5:0], printable_low[12:6], recovered_byte[20:13], zero pad
    output logic [akxor_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    import akxor_pkg::*;

    logic [15:0] session_key_reg;
    logic        decrypt_mode_reg;
    logic [15:0] running_key_reg;
    logic [15:0] running_key_next;

    stage_item_t stage_reg;
    stage_item_t stage_next;
    logic        stage_valid_reg;

    logic [5:0]  printable_high_reg;
    logic [6:0]  printable_low_reg;
    logic [7:0]  recovered_byte_reg;
    logic [5:0]  printable_high_next;
    logic [6:0]  printable_low_next;
    logic [7:0]  recovered_byte_next;
    logic        m_valid_reg;

    logic        advance;
    logic        s_accept;
    logic        cfg_accept;

    logic [7:0]  hi_off;
    logic [7:0]  lo_off;
    logic [15:0] key_used;
    logic [7:0]  key_mask;
    logic [7:0]  enc_value;
    logic [7:0]  plain_used;
    logic [15:0] key_sum;
    logic [31:0] key_prod;

    assign advance    = !m_valid_reg || m_tready;
    assign s_tready   = !stage_valid_reg || advance;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // First stage: fold the pair, (hi-33)*92 + (lo-33) modulo 256
    always_comb begin
        hi_off                      = s_tdata[15:8] - CHAR_BASE;
        lo_off                      = s_tdata[23:16] - CHAR_BASE;
        stage_next.start_of_message = s_tuser;
        stage_next.plain_byte       = s_tdata[7:0];
        stage_next.cipher_value     = 8'(hi_off * CHAR_RADIX) + lo_off;
    end

    // Second stage: mask, split into characters or recover the byte, advance the running key
    always_comb begin
        key_used  = stage_reg.start_of_message ? session_key_reg : running_key_reg;
        key_mask  = key_used[15:8] ^ (session_key_reg[7:0] & BYTE_MASK);
        enc_value = stage_reg.plain_byte ^ key_mask;

        printable_high_next = '0;
        printable_low_next  = '0;
        recovered_byte_next = '0;
        if (decrypt_mode_reg) begin
            plain_used          = stage_reg.cipher_value ^ key_mask;
            recovered_byte_next = plain_used;
        end else begin
            plain_used = stage_reg.plain_byte;
            if (enc_value >= 8'(2 * CHAR_RADIX)) begin
                printable_high_next = 6'(CHAR_BASE + 8'd2);
                printable_low_next  = 7'(CHAR_BASE + enc_value - 8'(2 * CHAR_RADIX));
            end else if (enc_value >= CHAR_RADIX) begin
                printable_high_next = 6'(CHAR_BASE + 8'd1);
                printable_low_next  = 7'(CHAR_BASE + enc_value - CHAR_RADIX);
            end else begin
                printable_high_next = 6'(CHAR_BASE);
                printable_low_next  = 7'(CHAR_BASE + enc_value);
            end
        end

        key_sum          = {8'd0, plain_used} + key_used;
        key_prod         = key_sum * KEY_MUL;
        running_key_next = key_prod[15:0] + KEY_ADD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_key_reg  <= '0;
            decrypt_mode_reg <= 1'b0;
            running_key_reg  <= '0;
            stage_valid_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_accept) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_SESSION_KEY:  session_key_reg  <= cfg_data;
                    REG_DECRYPT_MODE: decrypt_mode_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                stage_valid_reg <= 1'b1;
            end else if (advance) begin
                stage_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= stage_valid_reg;
                if (stage_valid_reg) begin
                    running_key_reg <= running_key_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stage_reg <= stage_next;
        end
        if (advance && stage_valid_reg) begin
            printable_high_reg <= printable_high_next;
            printable_low_reg  <= printable_low_next;
            recovered_byte_reg <= recovered_byte_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, recovered_byte_reg, printable_low_reg, printable_high_reg};

    // A full input register only takes a new item when it drains in the same cycle
    a_stage_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && stage_valid_reg) |-> advance)
        else $error("stage register overwritten");

    // Back-pressure on the input only with both registers full and output stalled
    a_ready_low_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (stage_valid_reg && m_valid_reg && !m_tready))
        else $error("input stalled without cause");

    // At most one mode's fields carry data
    a_mode_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (printable_high_reg == '0 || recovered_byte_reg == '0))
        else $error("both encrypt and decrypt fields set");

    // Encrypted characters stay in the printable range
    a_printable_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && printable_high_reg != '0) |->
            (printable_high_reg >= 6'd33 && printable_high_reg <= 6'd35
             && printable_low_reg >= 7'd33 && printable_low_reg <= 7'd124))
        else $error("printable character out of range");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench for the autokey XOR printable cipher unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import akxor_pkg::*;

    localparam int unsigned CH_BASE  = 33;
    localparam int unsigned CH_RADIX = 92;
    localparam int unsigned KEY_M    = 52845;
    localparam int unsigned KEY_A    = 22719;
    localparam int          SETTLE_CYCLES = 8;

    typedef struct packed {
        logic       sof;
        logic [7:0] plain_byte;
        logic [7:0] hi_ch;
        logic [7:0] lo_ch;
    } cipher_in_t;

    typedef struct packed {
        logic [5:0] prn_hi;
        logic [6:0] prn_lo;
        logic [7:0] rec_byte;
    } cipher_out_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [0:0]          cfg_index = '0;
    logic [15:0]         cfg_data  = '0;

    autokey_xor_printable_cipher_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // predictor state, mirrors the block's registers
    logic [15:0] sess_key = '0;
    logic        dec_mode = 1'b0;
    logic [15:0] run_key  = '0;

    cipher_in_t  pending_items[$];
    cipher_out_t expected_cipher_out[$];

    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    int          stall_left    = 0;
    int          fail_count    = 0;
    int          n_enc = 0, n_dec = 0, n_sof = 0, n_cfg = 0;

    function automatic cipher_out_t cipher_step(cipher_in_t it);
        cipher_out_t r;
        logic [7:0]  mask, khi, v, p;
        logic [31:0] nk;
        if (it.sof)
            run_key = sess_key;
        mask = sess_key[7:0];
        khi  = run_key[15:8];
        r    = '0;
        if (!dec_mode) begin
            p        = it.plain_byte;
            v        = p ^ khi ^ mask;
            r.prn_hi = 6'(CH_BASE + v / CH_RADIX);
            r.prn_lo = 7'(CH_BASE + v % CH_RADIX);
        end else begin
            // out-of-range characters simply wrap mod 256
            v          = 8'((it.hi_ch - CH_BASE) * CH_RADIX + (it.lo_ch - CH_BASE));
            p          = v ^ mask ^ khi;
            r.rec_byte = p;
        end
        nk      = (32'(p) + 32'(run_key)) * KEY_M + KEY_A;
        run_key = nk[15:0];
        return r;
    endfunction

    // sender
    always @(posedge aclk) begin : drv_p
        cipher_in_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                it = pending_items.pop_front();
                s_tuser  <= it.sof;
                s_tdata  <= {it.lo_ch, it.hi_ch, it.plain_byte};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a counted hold-off
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // monitor and checker
    always @(posedge aclk) begin : mon_p
        cipher_in_t  it;
        cipher_out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                n_cfg++;
                case (cfg_reg_t'(cfg_index))
                    REG_SESSION_KEY:  sess_key = cfg_data;
                    REG_DECRYPT_MODE: dec_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                it.sof        = s_tuser;
                it.plain_byte = s_tdata[7:0];
                it.hi_ch      = s_tdata[15:8];
                it.lo_ch      = s_tdata[23:16];
                if (dec_mode) n_dec++; else n_enc++;
                if (it.sof) n_sof++;
                expected_cipher_out.push_back(cipher_step(it));
            end
            if (m_tvalid && m_tready) begin
                if (expected_cipher_out.size() == 0) begin
                    $error("unexpected result item, tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_cipher_out.pop_front();
                    if (m_tdata[5:0] !== want.prn_hi) begin
                        $error("printable_high: expected %0d, got %0d", want.prn_hi,
                               m_tdata[5:0]);
                        fail_count++;
                    end
                    if (m_tdata[12:6] !== want.prn_lo) begin
                        $error("printable_low: expected %0d, got %0d", want.prn_lo,
                               m_tdata[12:6]);
                        fail_count++;
                    end
                    if (m_tdata[20:13] !== want.rec_byte) begin
                        $error("recovered_byte: expected %0d, got %0d", want.rec_byte,
                               m_tdata[20:13]);
                        fail_count++;
                    end
                    if (m_tdata[23:21] !== 3'b000) begin
                        $error("pad: expected 0, got %0d", m_tdata[23:21]);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || expected_cipher_out.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        wait_idle();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic push_item(logic sof, logic [7:0] pb, logic [7:0] hc, logic [7:0] lc);
        cipher_in_t it;
        it = '{sof: sof, plain_byte: pb, hi_ch: hc, lo_ch: lc};
        pending_items.push_back(it);
    endtask

    // messages of random length; decrypt runs mostly carry valid character pairs
    task automatic queue_random(bit decrypting, int count);
        cipher_in_t  it;
        int          msg_left;
        int unsigned v;
        msg_left = 0;
        for (int i = 0; i < count; i++) begin
            it.plain_byte = 8'($urandom);
            it.hi_ch      = 8'($urandom);
            it.lo_ch      = 8'($urandom);
            it.sof        = 1'b0;
            if (msg_left == 0) begin
                msg_left = $urandom_range(16, 1);
                it.sof   = ($urandom_range(9) != 0);
            end
            msg_left--;
            if (decrypting && $urandom_range(9) >= 2) begin
                v        = $urandom_range(255);
                it.hi_ch = 8'(CH_BASE + v / CH_RADIX);
                it.lo_ch = 8'(CH_BASE + v % CH_RADIX);
            end
            pending_items.push_back(it);
        end
    endtask

    initial begin : stim_p
        int unsigned src_pct[4];
        int unsigned snk_pct[4];
        src_pct = '{0, 71, 0, 23};
        snk_pct = '{0, 0, 71, 23};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // encrypt from reset values, no start flag
        push_item(1'b0, 8'h00, 8'hFF, 8'h00);
        push_item(1'b0, 8'hFF, 8'h00, 8'hFF);
        write_reg(REG_SESSION_KEY, 16'hFFFF);
        push_item(1'b1, 8'h00, 8'h00, 8'h00);
        push_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
        push_item(1'b0, 8'h5A, 8'hA5, 8'h5A);
        push_item(1'b0, 8'hA5, 8'h5A, 8'hA5);
        // key changed mid-message: mask moves now, running key keeps going
        write_reg(REG_SESSION_KEY, 16'h0000);
        push_item(1'b0, 8'h3C, 8'h00, 8'h00);

        // decrypt: printable extremes and out-of-range characters
        write_reg(REG_SESSION_KEY, 16'hFFFF);
        write_reg(REG_DECRYPT_MODE, 16'd1);
        push_item(1'b1, 8'hFF, 8'd33,  8'd33);
        push_item(1'b0, 8'h00, 8'd35,  8'd124);
        push_item(1'b0, 8'hFF, 8'd0,   8'd0);
        push_item(1'b0, 8'h00, 8'd255, 8'd255);
        push_item(1'b0, 8'hFF, 8'd34,  8'd200);
        push_item(1'b0, 8'h00, 8'd200, 8'd34);
        write_reg(REG_SESSION_KEY, 16'h0000);
        push_item(1'b0, 8'h81, 8'd40,  8'd50);
        push_item(1'b1, 8'h7E, 8'd34,  8'd83);

        // random phases across idle patterns, keys and both modes
        for (int ph = 0; ph < 4; ph++) begin
            for (int md = 0; md < 2; md++) begin
                wait_idle();
                src_idle_pct  = src_pct[ph];
                snk_stall_pct = snk_pct[ph];
                write_reg(REG_SESSION_KEY, (ph == 0) ? 16'h0000 :
                                           (ph == 1) ? 16'hFFFF : 16'($urandom));
                write_reg(REG_DECRYPT_MODE, 16'(md));
                queue_random(md[0], 60);
            end
        end

        // long receiver hold-off while the sender keeps offering items
        wait_idle();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_reg(REG_SESSION_KEY, 16'($urandom));
        write_reg(REG_DECRYPT_MODE, 16'd1);
        stall_left = 200;
        queue_random(1'b1, 40);
        // sender waits for every result before continuing the stream
        wait_idle();
        queue_random(1'b1, 20);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_cipher_out.size() != 0) begin
            $error("%0d expected results never arrived", expected_cipher_out.size());
            fail_count++;
        end
        $display("Run covered %0d encrypt and %0d decrypt items, %0d message starts,",
                 n_enc, n_dec, n_sof);
        $display("%0d register writes, under mixed sender and receiver idling.", n_cfg);
        if (fail_count == 0) begin
            $display("autokey_xor_printable_cipher_unit regression: pass");
        end else begin
            $display("autokey_xor_printable_cipher_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Timed out waiting for the stream to drain.");
        $display("autokey_xor_printable_cipher_unit regression: fail");
        $finish;
    end

endmodule
